/* rtl/core/wea_pkg.sv */
package wea_pkg;

   localparam int DEFAULT_HISTORY_DEPTH = 20;

   localparam int ERR_W     = 16;
   localparam int TOTAL_W   = 18;
   localparam int AVG_REG_W = 18;
   localparam int AVG_W     = 17;
   localparam int FILL_W    = 5;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

/* rtl/core/wea_channels.sv */
interface wea_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [wea_pkg::ERR_W-1:0]    loop_error;
   logic signed [wea_pkg::ERR_W-1:0]    applied_offset;

   modport source (output valid, kind, loop_error, applied_offset, input ready);
   modport sink   (input valid, kind, loop_error, applied_offset, output ready);
endinterface

interface wea_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [wea_pkg::AVG_W-1:0]    mean_error;
   logic        [wea_pkg::FILL_W-1:0]   fill_count;

   modport source (output valid, mean_error, fill_count, input ready);
   modport sink   (input valid, mean_error, fill_count, output ready);
endinterface

/* rtl/core/wea_cell.sv */
module wea_cell (
   input  logic                                clock,
   input  logic                                shift_en,
   input  logic signed [wea_pkg::TOTAL_W-1:0]  data_in,
   output logic signed [wea_pkg::TOTAL_W-1:0]  data_out
);

   logic signed [wea_pkg::TOTAL_W-1:0] value_ff;
   logic signed [wea_pkg::TOTAL_W-1:0] value_in;

   assign value_in = shift_en ? data_in : value_ff;
   assign data_out = value_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* rtl/core/wea_div.sv */
module wea_div #(
   parameter int DVD_W = 23,
   parameter int DVS_W = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DVD_W-1:0]  dividend,
   input  logic        [DVS_W-1:0]  divisor,
   output logic                     done,
   output logic signed [DVD_W-1:0]  quotient
);

   localparam int ITER_W = $clog2(DVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DVD_W-1:0]  work_ff, work_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;

   // One quotient bit per cycle: the dividend shifts out at the top while
   // quotient bits shift in at the bottom of the same register.
   assign trial = {rem_ff, work_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      iter_in = iter_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DVD_W-1];
         work_in = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
         iter_in = ITER_W'(DVD_W);
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = diff[DVS_W-1:0];
            work_in = {work_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DVS_W-1:0];
            work_in = {work_ff[DVD_W-2:0], 1'b0};
         end
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(work_ff) : $signed(work_ff);

endmodule

/* rtl/core/windowed_error_average_unit.sv */
// Moving average of frequency-error measurements. Each add word stores
// loop_error + applied_offset in a shift chain of HISTORY_DEPTH cells
// (newest at the head, the oldest dropped off the tail once the chain is full),
// updates a running sum, and divides it by the number of entries held,
// truncating toward zero. A clear word empties the history but keeps the last
// average. Every word yields one result word carrying the average and the
// fill count. Words are handled one at a time: an add word passes through the
// start and divide states, in which the restoring divider produces one quotient
// bit per cycle, to the emit state; a clear word goes straight to emit.
// The emit state writes the result register once it is free. A new word is
// accepted as soon as the previous result sits in the output register.
module windowed_error_average_unit #(
   parameter int HISTORY_DEPTH = wea_pkg::DEFAULT_HISTORY_DEPTH
) (
   input logic       clock,
   input logic       reset,
   wea_req_if.sink   req_chan,
   wea_rsp_if.source rsp_chan
);

   localparam int SUM_W = wea_pkg::TOTAL_W + $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   wea_pkg::state_type state_ff, state_in;

   logic                                 req_accept;
   logic                                 add_accept;
   logic                                 full;
   logic signed [wea_pkg::TOTAL_W-1:0]   total;
   logic signed [wea_pkg::TOTAL_W-1:0]   chain [HISTORY_DEPTH+1];
   logic signed [SUM_W-1:0]              sum_ff, sum_in;
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic signed [wea_pkg::AVG_REG_W-1:0] avg_ff;
   logic                                 div_start;
   logic                                 div_done;
   logic signed [SUM_W-1:0]              div_quot;
   logic                                 emit;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [wea_pkg::AVG_W-1:0]            rsp_avg_ff;
   logic [wea_pkg::FILL_W-1:0]           rsp_fill_ff;
   logic [wea_pkg::FILL_W+CNT_W-1:0]     fill_ext;

   assign req_chan.ready = (state_ff == wea_pkg::ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign add_accept     = req_accept && (req_chan.kind == wea_pkg::KIND_ADD);

   assign total = wea_pkg::TOTAL_W'(req_chan.loop_error)
                + wea_pkg::TOTAL_W'(req_chan.applied_offset);
   assign full  = (count_ff == CNT_W'(HISTORY_DEPTH));

   assign chain[0] = total;

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      wea_cell u_cell (
         .clock    (clock),
         .shift_en (add_accept),
         .data_in  (chain[i]),
         .data_out (chain[i+1])
      );
   end

   // The tail cell holds the oldest entry; it is only read when the chain is full.
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (req_accept) begin
         if (req_chan.kind == wea_pkg::KIND_CLEAR) begin
            sum_in   = '0;
            count_in = '0;
         end else if (full) begin
            sum_in = sum_ff + SUM_W'(total) - SUM_W'(chain[HISTORY_DEPTH]);
         end else begin
            sum_in   = sum_ff + SUM_W'(total);
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         wea_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_chan.kind == wea_pkg::KIND_CLEAR) ?
                          wea_pkg::ST_EMIT : wea_pkg::ST_START;
            end
         end
         wea_pkg::ST_START: begin
            div_start = 1'b1;
            state_in  = wea_pkg::ST_DIVIDE;
         end
         wea_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = wea_pkg::ST_EMIT;
            end
         end
         wea_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               emit     = 1'b1;
               state_in = wea_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wea_pkg::ST_IDLE;
         end
      endcase
   end

   wea_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign fill_ext = {{wea_pkg::FILL_W{1'b0}}, count_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wea_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (div_done) begin
            avg_ff <= div_quot[wea_pkg::AVG_REG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_avg_ff  <= avg_ff[wea_pkg::AVG_W-1:0];
         rsp_fill_ff <= fill_ext[wea_pkg::FILL_W-1:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.mean_error = rsp_avg_ff;
   assign rsp_chan.fill_count = rsp_fill_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("history count exceeds depth");

   a_add_fills: assert property (@(posedge clock) disable iff (reset)
      add_accept |=> count_ff != '0)
      else $error("add word left history empty");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.kind == wea_pkg::KIND_CLEAR)
         |=> count_ff == '0 && sum_ff == '0)
      else $error("clear word did not empty history");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == wea_pkg::ST_DIVIDE)
      else $error("divider finished outside divide phase");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == wea_pkg::ST_EMIT))
      else $error("result raised outside emit phase");
`endif

endmodule
